[rtl/core/wrl_pkg.sv]
// ============================================================================
// wrl_pkg
// Shared codes, defaults and the job word passed from the request front end
// to the result back end of the reader-writer lock manager.
// ============================================================================
package wrl_pkg;

    // Default configuration
    localparam int DEF_READ_QUEUE_DEPTH  = 16;
    localparam int DEF_WRITE_QUEUE_DEPTH = 16;
    localparam int DEF_MAX_READERS       = 255;
    localparam int DEF_TASK_ID_BITS      = 8;

    // Fixed widths of the job word (queue depths go up to 64)
    localparam int QADDR_BITS  = 6;
    localparam int QCOUNT_BITS = 7;

    // Request codes
    localparam logic [1:0] FN_ACQ_READ  = 2'd0;
    localparam logic [1:0] FN_ACQ_WRITE = 2'd1;
    localparam logic [1:0] FN_REL_READ  = 2'd2;
    localparam logic [1:0] FN_REL_WRITE = 2'd3;

    // Result status codes
    localparam logic [2:0] ST_GRANTED  = 3'd0;
    localparam logic [2:0] ST_QUEUED   = 3'd1;
    localparam logic [2:0] ST_WOKEN    = 3'd2;
    localparam logic [2:0] ST_RELEASED = 3'd3;
    localparam logic [2:0] ST_ERROR    = 3'd4;

    // Wait queue operations carried out by the back end
    localparam logic [2:0] OP_NONE    = 3'd0;
    localparam logic [2:0] OP_PUSH_RD = 3'd1;
    localparam logic [2:0] OP_PUSH_WR = 3'd2;
    localparam logic [2:0] OP_WAKE_WR = 3'd3;
    localparam logic [2:0] OP_WAKE_RD = 3'd4;

    // One classified request
    typedef struct packed {
        logic [2:0]             op;
        logic [QADDR_BITS-1:0]  addr;
        logic [QCOUNT_BITS-1:0] count;
        logic [2:0]             status;
        logic [7:0]             who;
        logic [7:0]             readers_now;
        logic                   writer_now;
    } wrl_job_t;

endpackage

[rtl/core/wrl_front.sv]
// ============================================================================
// wrl_front
// Accepts lock requests, decides grant, queue, release or error, keeps the
// lock state and queue bookkeeping, and emits one job word per request.
// ============================================================================
module wrl_front #(
    parameter int READ_QUEUE_DEPTH  = 16,
    parameter int WRITE_QUEUE_DEPTH = 16,
    parameter int MAX_READERS       = 255,
    parameter int TASK_ID_BITS      = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [1:0]        func,
    input  logic [7:0]        task_id,
    output logic              busy,
    input  logic              full,
    output logic              push,
    output wrl_pkg::wrl_job_t job
);
    import wrl_pkg::*;

    localparam int ID_W = (TASK_ID_BITS < 8) ? TASK_ID_BITS : 8;
    localparam int RC_W = $clog2(MAX_READERS + 1);
    localparam int RF_W = $clog2(READ_QUEUE_DEPTH + 1);
    localparam int WF_W = $clog2(WRITE_QUEUE_DEPTH + 1);
    localparam int WP_W = (WRITE_QUEUE_DEPTH > 1) ? $clog2(WRITE_QUEUE_DEPTH) : 1;

    logic            writer_reg, writer_next;
    logic [RC_W-1:0] readers_reg, readers_next;
    logic [RF_W-1:0] rfill_reg, rfill_next;
    logic [WF_W-1:0] wfill_reg, wfill_next;
    logic [WP_W-1:0] whead_reg, whead_next;
    logic [WP_W-1:0] wtail_reg, wtail_next;
    logic [ID_W-1:0] id;
    logic            wake;
    logic            accept;

    assign id     = task_id[ID_W-1:0];
    assign busy   = full;
    assign accept = start && !full;
    assign push   = accept;

    // Classify the request and work out the next lock state
    always_comb
    begin
        writer_next  = writer_reg;
        readers_next = readers_reg;
        rfill_next   = rfill_reg;
        wfill_next   = wfill_reg;
        whead_next   = whead_reg;
        wtail_next   = wtail_reg;
        wake         = 1'b0;
        job          = '0;
        job.op       = OP_NONE;
        job.status   = ST_ERROR;
        job.who      = 8'(id);

        case (func)
            FN_ACQ_READ:
            begin
                if (!writer_reg && wfill_reg == '0)
                begin
                    if (readers_reg < RC_W'(MAX_READERS))
                    begin
                        readers_next = readers_reg + 1'b1;
                        job.status   = ST_GRANTED;
                    end
                end
                else if (rfill_reg < RF_W'(READ_QUEUE_DEPTH))
                begin
                    job.op     = OP_PUSH_RD;
                    job.addr   = QADDR_BITS'(rfill_reg);
                    rfill_next = rfill_reg + 1'b1;
                    job.status = ST_QUEUED;
                end
            end
            FN_ACQ_WRITE:
            begin
                if (!writer_reg && readers_reg == '0)
                begin
                    writer_next = 1'b1;
                    job.status  = ST_GRANTED;
                end
                else if (wfill_reg < WF_W'(WRITE_QUEUE_DEPTH))
                begin
                    job.op     = OP_PUSH_WR;
                    job.addr   = QADDR_BITS'(wtail_reg);
                    wtail_next = (wtail_reg == WP_W'(WRITE_QUEUE_DEPTH - 1)) ?
                                 '0 : wtail_reg + 1'b1;
                    wfill_next = wfill_reg + 1'b1;
                    job.status = ST_QUEUED;
                end
            end
            FN_REL_READ:
            begin
                if (readers_reg != '0)
                begin
                    readers_next = readers_reg - 1'b1;
                    job.status   = ST_RELEASED;
                    wake         = (readers_reg == RC_W'(1)) && (wfill_reg != '0);
                end
            end
            FN_REL_WRITE:
            begin
                writer_next = 1'b0;
                job.status  = ST_RELEASED;
                wake        = (wfill_reg != '0) || (rfill_reg != '0);
            end
            default:
            begin
                job.status = ST_ERROR;
            end
        endcase

        // Wake one writer, or else every queued reader
        if (wake)
        begin
            if (wfill_reg != '0)
            begin
                job.op     = OP_WAKE_WR;
                job.addr   = QADDR_BITS'(whead_reg);
                whead_next = (whead_reg == WP_W'(WRITE_QUEUE_DEPTH - 1)) ?
                             '0 : whead_reg + 1'b1;
                wfill_next = wfill_reg - 1'b1;
            end
            else
            begin
                job.op     = OP_WAKE_RD;
                job.count  = QCOUNT_BITS'(rfill_reg);
                rfill_next = '0;
            end
        end

        job.readers_now = 8'(readers_next);
        job.writer_now  = writer_next;
    end

    // Commit state on an accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            writer_reg  <= 1'b0;
            readers_reg <= '0;
            rfill_reg   <= '0;
            wfill_reg   <= '0;
            whead_reg   <= '0;
            wtail_reg   <= '0;
        end
        else if (accept)
        begin
            writer_reg  <= writer_next;
            readers_reg <= readers_next;
            rfill_reg   <= rfill_next;
            wfill_reg   <= wfill_next;
            whead_reg   <= whead_next;
            wtail_reg   <= wtail_next;
        end
    end

endmodule

[rtl/core/wrl_job_fifo.sv]
// ============================================================================
// wrl_job_fifo
// Two-entry queue of job words between the front end and the back end.
// ============================================================================
module wrl_job_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  wrl_pkg::wrl_job_t push_job,
    output logic              full,
    input  logic              pop,
    output logic              valid,
    output wrl_pkg::wrl_job_t head_job
);
    import wrl_pkg::*;

    wrl_job_t   slots_reg [0:1];
    logic       wptr_reg;
    logic       rptr_reg;
    logic [1:0] count_reg;

    assign full     = (count_reg == 2'd2);
    assign valid    = (count_reg != 2'd0);
    assign head_job = slots_reg[rptr_reg];

    // Hold the payload
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wptr_reg] <= push_job;
        end
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= !wptr_reg;
            end
            if (pop)
            begin
                rptr_reg <= !rptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

[rtl/core/wrl_back.sv]
// ============================================================================
// wrl_back
// Carries out job words: writes waiting task ids into the wait queues, reads
// woken ids back out, and drives one result word per cycle.
// ============================================================================
module wrl_back #(
    parameter int READ_QUEUE_DEPTH  = 16,
    parameter int WRITE_QUEUE_DEPTH = 16,
    parameter int TASK_ID_BITS      = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              job_valid,
    input  wrl_pkg::wrl_job_t job,
    output logic              pop,
    output logic              strobe,
    output logic [2:0]        status,
    output logic [7:0]        who,
    output logic [7:0]        readers_now,
    output logic              writer_now,
    output logic              last
);
    import wrl_pkg::*;

    localparam int ID_W = (TASK_ID_BITS < 8) ? TASK_ID_BITS : 8;
    localparam int RF_W = $clog2(READ_QUEUE_DEPTH + 1);
    localparam int RP_W = (READ_QUEUE_DEPTH > 1) ? $clog2(READ_QUEUE_DEPTH) : 1;
    localparam int WP_W = (WRITE_QUEUE_DEPTH > 1) ? $clog2(WRITE_QUEUE_DEPTH) : 1;

    localparam logic SM_IDLE = 1'b0;
    localparam logic SM_WAKE = 1'b1;

    logic [ID_W-1:0] wr_mem [0:WRITE_QUEUE_DEPTH-1];
    logic [ID_W-1:0] rd_mem [0:READ_QUEUE_DEPTH-1];
    logic [ID_W-1:0] wr_rdata;
    logic [ID_W-1:0] rd_rdata;

    logic            state_reg;
    logic            wake_wr_reg;
    logic [RP_W-1:0] raddr_reg;
    logic [RF_W-1:0] remain_reg;
    logic            strobe_reg;
    logic [2:0]      status_reg;
    logic [7:0]      who_reg;
    logic [7:0]      readers_reg;
    logic            writer_reg;
    logic            last_reg;

    logic            is_wake;
    logic            rd_re;
    logic [RP_W-1:0] rd_raddr;

    assign pop     = job_valid && (state_reg == SM_IDLE);
    assign is_wake = (job.op == OP_WAKE_WR) || (job.op == OP_WAKE_RD);
    assign rd_re   = (pop && job.op == OP_WAKE_RD) ||
                     (state_reg == SM_WAKE && !wake_wr_reg && remain_reg > RF_W'(1));
    assign rd_raddr = (state_reg == SM_IDLE) ? '0 : raddr_reg;

    assign strobe      = strobe_reg;
    assign status      = status_reg;
    assign who         = who_reg;
    assign readers_now = readers_reg;
    assign writer_now  = writer_reg;
    assign last        = last_reg;

    // Write queue memory: push at the tail, read the head on a wake
    always_ff @(posedge clk)
    begin
        if (pop && job.op == OP_PUSH_WR)
        begin
            wr_mem[job.addr[WP_W-1:0]] <= job.who[ID_W-1:0];
        end
        if (pop && job.op == OP_WAKE_WR)
        begin
            wr_rdata <= wr_mem[job.addr[WP_W-1:0]];
        end
    end

    // Read queue memory: push at the fill, drain from entry zero upward
    always_ff @(posedge clk)
    begin
        if (pop && job.op == OP_PUSH_RD)
        begin
            rd_mem[job.addr[RP_W-1:0]] <= job.who[ID_W-1:0];
        end
        if (rd_re)
        begin
            rd_rdata <= rd_mem[rd_raddr];
        end
    end

    // Sequence the answer word and any woken words
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= SM_IDLE;
            wake_wr_reg <= 1'b0;
            raddr_reg   <= '0;
            remain_reg  <= '0;
            strobe_reg  <= 1'b0;
        end
        else
        begin
            case (state_reg)
                SM_IDLE:
                begin
                    strobe_reg <= pop;
                    if (pop && is_wake)
                    begin
                        state_reg   <= SM_WAKE;
                        wake_wr_reg <= (job.op == OP_WAKE_WR);
                        remain_reg  <= (job.op == OP_WAKE_WR) ? RF_W'(1) : RF_W'(job.count);
                        raddr_reg   <= RP_W'(1);
                    end
                end
                SM_WAKE:
                begin
                    strobe_reg <= 1'b1;
                    remain_reg <= remain_reg - 1'b1;
                    if (remain_reg == RF_W'(1))
                    begin
                        state_reg <= SM_IDLE;
                    end
                    if (rd_re)
                    begin
                        raddr_reg <= raddr_reg + 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= SM_IDLE;
                end
            endcase
        end
    end

    // Load the result payload
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            status_reg  <= job.status;
            who_reg     <= job.who;
            readers_reg <= job.readers_now;
            writer_reg  <= job.writer_now;
            last_reg    <= !is_wake;
        end
        else if (state_reg == SM_WAKE)
        begin
            status_reg <= ST_WOKEN;
            who_reg    <= 8'(wake_wr_reg ? wr_rdata : rd_rdata);
            last_reg   <= (remain_reg == RF_W'(1));
        end
    end

endmodule

[rtl/core/writer_preferring_rwlock_manager.sv]
// ============================================================================
// writer_preferring_rwlock_manager
// Reader-writer lock manager with writer preference and FIFO wait queues.
// ============================================================================
// A request is taken on a clock edge with start high and busy low. With the
// back end idle, its job word passes through the job queue and the result
// registers before its first result word is strobed. A wake still in
// progress holds it back until the woken words left are sent. The receiver
// cannot stall, so results must be taken as they come. A request that wakes
// waiters is followed by one word per woken task on consecutive cycles (one
// writer, or every queued reader in order), with last high on the final
// word. The back end sends result words one after another; requests queue
// in a two-entry job queue and busy rises while that queue is full, so new
// requests are taken while the back end still sends words of earlier ones.
// Wait queue memories need no clearing after reset.
module writer_preferring_rwlock_manager #(
    parameter int READ_QUEUE_DEPTH  = wrl_pkg::DEF_READ_QUEUE_DEPTH,
    parameter int WRITE_QUEUE_DEPTH = wrl_pkg::DEF_WRITE_QUEUE_DEPTH,
    parameter int MAX_READERS       = wrl_pkg::DEF_MAX_READERS,
    parameter int TASK_ID_BITS      = wrl_pkg::DEF_TASK_ID_BITS
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] func,
    input  logic [7:0] task_id,
    output logic       strobe,
    output logic [2:0] status,
    output logic [7:0] who,
    output logic [7:0] readers_now,
    output logic       writer_now,
    output logic       last
);
    import wrl_pkg::*;

    wrl_job_t front_job;
    wrl_job_t head_job;
    logic     push;
    logic     full;
    logic     pop;
    logic     job_valid;

    // Classify requests
    wrl_front #(
        .READ_QUEUE_DEPTH  (READ_QUEUE_DEPTH),
        .WRITE_QUEUE_DEPTH (WRITE_QUEUE_DEPTH),
        .MAX_READERS       (MAX_READERS),
        .TASK_ID_BITS      (TASK_ID_BITS)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .func    (func),
        .task_id (task_id),
        .busy    (busy),
        .full    (full),
        .push    (push),
        .job     (front_job)
    );

    // Decouple front and back
    wrl_job_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (front_job),
        .full     (full),
        .pop      (pop),
        .valid    (job_valid),
        .head_job (head_job)
    );

    // Carry out jobs and drive results
    wrl_back #(
        .READ_QUEUE_DEPTH  (READ_QUEUE_DEPTH),
        .WRITE_QUEUE_DEPTH (WRITE_QUEUE_DEPTH),
        .TASK_ID_BITS      (TASK_ID_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .job_valid   (job_valid),
        .job         (head_job),
        .pop         (pop),
        .strobe      (strobe),
        .status      (status),
        .who         (who),
        .readers_now (readers_now),
        .writer_now  (writer_now),
        .last        (last)
    );

    // A writer and active readers never hold the lock together
    a_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> !(writer_now && readers_now != 8'd0))
        else $error("writer and readers reported together");

    // Words of one request come back to back until last
    a_burst: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !last) |=> strobe)
        else $error("result burst broken before last word");

    // A woken word only follows an unfinished word of the same request
    a_woken_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && status == ST_WOKEN) |-> ($past(strobe) && !$past(last)))
        else $error("woken word without a preceding answer word");

    // The job queue is never pushed while full
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("job queue overrun");

endmodule

[test/writer_preferring_rwlock_manager_tb.sv]
// ----------------------------------------------------------------------------
// writer_preferring_rwlock_manager_tb
// Self-checking bench for the writer-preferring reader-writer lock manager.
// It sends lock requests through the start/busy handshake and keeps its own
// model of the lock: holder, reader count, waiting flags and both FIFO wait
// queues. Every accepted request queues the result words it must cause. Each
// strobed word is checked field by field against the oldest queued word.
// The tests cover each request code, both queue-full cases, the 17-word
// reader wake, and random traffic in which woken tasks retry.
// ----------------------------------------------------------------------------
module writer_preferring_rwlock_manager_tb;
    import wrl_pkg::*;

    localparam int RD_DEPTH     = DEF_READ_QUEUE_DEPTH;
    localparam int WR_DEPTH     = DEF_WRITE_QUEUE_DEPTH;
    localparam int READER_LIMIT = DEF_MAX_READERS;
    localparam int STALL_LIMIT  = 500;
    localparam int TAIL_CYCLES  = 20;
    localparam int MAX_PRINTS   = 60;

    // One result word as the lock should report it
    typedef struct packed {
        logic [2:0] status;
        logic [7:0] who;
        logic [7:0] readers_now;
        logic       writer_now;
        logic       last;
    } lock_word_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       start;
    logic       busy;
    logic [1:0] func;
    logic [7:0] task_id;
    logic       strobe;
    logic [2:0] status;
    logic [7:0] who;
    logic [7:0] readers_now;
    logic       writer_now;
    logic       last;

    // Lock model state
    logic       held_by_writer  = 1'b0;
    logic [7:0] lock_owner      = 8'd0;
    int         active_readers  = 0;
    logic       writers_waiting = 1'b0;
    logic       readers_waiting = 1'b0;
    logic [7:0] writer_line[$];
    logic [7:0] reader_line[$];
    logic [7:0] woken_ids[$];

    // Woken tasks that still have to send their request again
    logic [1:0] retry_func[$];
    logic [7:0] retry_id[$];

    lock_word_t expected_words[$];

    int error_count   = 0;
    int reqs_sent     = 0;
    int words_checked = 0;
    int peak_readers  = 0;
    int stall_cycles  = 0;
    int idle_pct      = 30;

    writer_preferring_rwlock_manager dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .func        (func),
        .task_id     (task_id),
        .strobe      (strobe),
        .status      (status),
        .who         (who),
        .readers_now (readers_now),
        .writer_now  (writer_now),
        .last        (last)
    );

    always #5 clk = ~clk;

    // Print one mismatch line and count it; keep the log short
    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        error_count++;
        if (error_count <= MAX_PRINTS)
            $display("MISMATCH word %0d %s: got %h want %h", words_checked, what, got, want);
    endtask

    // Hand out one queued writer, or else every queued reader in order
    task automatic wake_waiters();
        woken_ids = {};
        if (writer_line.size() != 0) begin
            woken_ids.push_back(writer_line.pop_front());
            retry_func.push_back(FN_ACQ_WRITE);
            retry_id.push_back(woken_ids[0]);
            if (writer_line.size() == 0)
                writers_waiting = 1'b0;
        end
        else if (reader_line.size() != 0) begin
            while (reader_line.size() != 0) begin
                woken_ids.push_back(reader_line[0]);
                retry_func.push_back(FN_ACQ_READ);
                retry_id.push_back(reader_line.pop_front());
            end
            readers_waiting = 1'b0;
        end
    endtask

    // Advance the lock model by one request and queue the words it causes
    task automatic predict_lock(input logic [1:0] f, input logic [7:0] id);
        logic [2:0] st;
        lock_word_t w;
        int         n;
        st = ST_ERROR;
        woken_ids = {};
        case (f)
            FN_ACQ_READ: begin
                if (!held_by_writer && !writers_waiting) begin
                    if (active_readers < READER_LIMIT) begin
                        active_readers++;
                        st = ST_GRANTED;
                    end
                end
                else if (reader_line.size() < RD_DEPTH) begin
                    reader_line.push_back(id);
                    readers_waiting = 1'b1;
                    st = ST_QUEUED;
                end
            end
            FN_ACQ_WRITE: begin
                if (!held_by_writer && active_readers == 0) begin
                    held_by_writer = 1'b1;
                    lock_owner = id;
                    st = ST_GRANTED;
                end
                else if (writer_line.size() < WR_DEPTH) begin
                    writer_line.push_back(id);
                    writers_waiting = 1'b1;
                    st = ST_QUEUED;
                end
            end
            FN_REL_READ: begin
                if (active_readers > 0) begin
                    active_readers--;
                    st = ST_RELEASED;
                    if (active_readers == 0 && writers_waiting)
                        wake_waiters();
                end
            end
            default: begin
                // Release write is carried out whoever sends it
                lock_owner = 8'd0;
                held_by_writer = 1'b0;
                st = ST_RELEASED;
                if (writers_waiting || readers_waiting)
                    wake_waiters();
            end
        endcase
        if (active_readers > peak_readers)
            peak_readers = active_readers;
        n = woken_ids.size();
        w.status = st;
        w.who = id;
        w.readers_now = active_readers[7:0];
        w.writer_now = held_by_writer;
        w.last = (n == 0);
        expected_words.push_back(w);
        for (int k = 0; k < n; k++) begin
            w.status = ST_WOKEN;
            w.who = woken_ids[k];
            w.last = (k == n - 1);
            expected_words.push_back(w);
        end
    endtask

    // Send one request word, idling first at random, and hold it until taken
    task automatic send_req(input logic [1:0] f, input logic [7:0] id);
        if ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        start <= 1'b1;
        func <= f;
        task_id <= id;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        reqs_sent++;
        predict_lock(f, id);
    endtask

    // Release everything until the lock is free and both queues are empty
    task automatic settle_lock();
        while (held_by_writer || writers_waiting || readers_waiting || active_readers != 0) begin
            if (active_readers != 0)
                send_req(FN_REL_READ, 8'($urandom_range(0, 255)));
            else
                send_req(FN_REL_WRITE, lock_owner);
        end
        retry_func = {};
        retry_id = {};
    endtask

    // Walk through every request code and the release corner cases
    task automatic test_each_op();
        send_req(FN_ACQ_READ, 8'h00);
        send_req(FN_ACQ_READ, 8'hFF);
        send_req(FN_REL_READ, 8'h00);
        send_req(FN_ACQ_WRITE, 8'hA5);   // waits behind a reader
        send_req(FN_ACQ_READ, 8'h5A);    // waits behind the waiting writer
        send_req(FN_REL_READ, 8'hFF);    // last reader leaves, writer woken
        send_req(FN_ACQ_WRITE, 8'hA5);
        send_req(FN_ACQ_READ, 8'h3C);
        send_req(FN_ACQ_WRITE, 8'hC3);
        send_req(FN_REL_WRITE, 8'hA5);   // writer preferred over readers
        send_req(FN_ACQ_WRITE, 8'hC3);
        send_req(FN_REL_WRITE, 8'h77);   // non-owner release, readers drained
        send_req(FN_ACQ_READ, 8'h5A);
        send_req(FN_ACQ_READ, 8'h3C);
        send_req(FN_REL_READ, 8'h5A);
        send_req(FN_REL_READ, 8'h3C);
        send_req(FN_REL_READ, 8'h81);    // no reader active
        send_req(FN_REL_WRITE, 8'h00);   // no writer holds the lock
        send_req(FN_REL_WRITE, 8'h12);
        retry_func = {};
        retry_id = {};
    endtask

    // Overfill both wait queues, then drain them including a full reader wake
    task automatic test_queue_limits();
        settle_lock();
        send_req(FN_ACQ_WRITE, 8'h80);
        for (int i = 0; i <= RD_DEPTH; i++)
            send_req(FN_ACQ_READ, 8'(8'h40 + i));
        for (int i = 0; i <= WR_DEPTH; i++)
            send_req(FN_ACQ_WRITE, 8'(8'h90 + i));
        settle_lock();
    endtask

    // Random traffic where woken tasks come back with their request
    task automatic test_random_traffic();
        logic [1:0] f;
        logic [7:0] id;
        int         r;
        for (int i = 0; i < 130; i++) begin
            // Hold a stretch in the middle with no idling at all
            idle_pct = (i >= 50 && i < 90) ? 0 : 30;
            r = $urandom_range(0, 99);
            if (retry_func.size() != 0 && r < 35) begin
                f = retry_func.pop_front();
                id = retry_id.pop_front();
            end
            else begin
                r = $urandom_range(0, 99);
                if (r < 30)
                    f = FN_ACQ_READ;
                else if (r < 50)
                    f = FN_ACQ_WRITE;
                else if (r < 75)
                    f = FN_REL_READ;
                else
                    f = FN_REL_WRITE;
                if ($urandom_range(0, 99) < 70)
                    id = 8'($urandom_range(0, 15));
                else
                    id = 8'($urandom_range(0, 255));
                if (f == FN_REL_WRITE && held_by_writer && $urandom_range(0, 99) < 80)
                    id = lock_owner;
            end
            send_req(f, id);
        end
        idle_pct = 30;
    endtask

    // Compare each strobed word with the oldest expected one
    always @(posedge clk) begin : check_results
        lock_word_t want;
        if (rst_n === 1'b1 && strobe !== 1'b0) begin
            if (expected_words.size() == 0) begin
                report_mismatch("word with none expected, who", who, 8'h00);
            end
            else begin
                want = expected_words.pop_front();
                if (status !== want.status)
                    report_mismatch("status", 8'(status), 8'(want.status));
                if (who !== want.who)
                    report_mismatch("who", who, want.who);
                if (readers_now !== want.readers_now)
                    report_mismatch("readers_now", readers_now, want.readers_now);
                if (writer_now !== want.writer_now)
                    report_mismatch("writer_now", 8'(writer_now), 8'(want.writer_now));
                if (last !== want.last)
                    report_mismatch("last", 8'(last), 8'(want.last));
            end
            words_checked++;
        end
    end

    // Drop the run if neither side moves a word for too long
    always @(posedge clk) begin
        if ((start === 1'b1 && busy === 1'b0) || strobe === 1'b1)
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Watchdog: no word moved for %0d cycles, %0d words still due",
                     stall_cycles, expected_words.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        rst_n = 1'b0;
        start = 1'b0;
        func = FN_ACQ_READ;
        task_id = 8'd0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_each_op();
        test_queue_limits();
        test_random_traffic();

        // Wait out every expected word, then a short tail for strays
        start <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d lock requests and checked %0d result words", reqs_sent,
                 words_checked);
        $display("Reached %0d active readers, filled both wait queues past depth", peak_readers);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

[sim.f]
rtl/core/wrl_pkg.sv
rtl/core/wrl_front.sv
rtl/core/wrl_job_fifo.sv
rtl/core/wrl_back.sv
rtl/core/writer_preferring_rwlock_manager.sv
test/writer_preferring_rwlock_manager_tb.sv
